### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RTL of the message stack (included by msbs_back).
// Assertions compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MSBS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MSBS_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) trig |=> cons) else $error(msg);
`else
`define MSBS_ASSERT(lbl, clk, rst_n, prop, msg)
`define MSBS_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg)
`endif
`endif

### hw/rtl/msbs_pkg.sv
// ----------------------------------------------------------------------------
// msbs_pkg
// Types and codes shared by the front end and the executor of the
// message stack.
// ----------------------------------------------------------------------------
package msbs_pkg;

    localparam int BYTE_W = 8;
    localparam int CNT_W  = 7;
    localparam int MLEN_W = 8;
    localparam int ST_W   = 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_TOO_LONG = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd3;

    // One classified command as it sits in the queue between front and back.
    typedef struct packed {
        logic              op;
        logic              first;
        logic              last;
        logic              too_long;
        logic [CNT_W-1:0]  cap;
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  limit;
    } t_cmd;

endpackage

### hw/rtl/msbs_ram.sv
// ----------------------------------------------------------------------------
// msbs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module msbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Read data holds until the next read, so a stalled consumer can wait.
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/msbs_front.sv
// ----------------------------------------------------------------------------
// msbs_front
// Accepts input items, classifies them into commands and queues them
// in a two-entry queue for the executor.
// ----------------------------------------------------------------------------
module msbs_front import msbs_pkg::*; #(
    parameter int MAX_MESSAGE = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_kind,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic [MLEN_W-1:0] i_message_length,
    input  logic              i_first_of_message,
    input  logic              i_last_of_message,
    input  logic [CNT_W-1:0]  i_read_limit,
    output logic              o_q_valid,
    output t_cmd              o_q_cmd,
    input  logic              i_q_pop
);

    t_cmd       r_buf [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    t_cmd       c_cmd;
    logic       push;

    // The too-long check is decided here; the back end gets its flag along with the
    // effective byte cap of the message.
    always_comb begin
        c_cmd.op       = (i_kind == OP_READ) ? OP_READ : OP_WRITE;
        c_cmd.first    = i_first_of_message;
        c_cmd.last     = i_last_of_message;
        c_cmd.too_long = i_message_length > MLEN_W'(MAX_MESSAGE);
        c_cmd.cap      = c_cmd.too_long ? CNT_W'(MAX_MESSAGE) : CNT_W'(i_message_length);
        c_cmd.data     = i_data_byte;
        c_cmd.limit    = i_read_limit;
    end

    assign o_in_stall = (r_count == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_cmd    = r_buf[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_q_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, push} - {1'b0, i_q_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= c_cmd;
        end
    end

endmodule

### hw/rtl/msbs_back.sv
// ----------------------------------------------------------------------------
// msbs_back
// Executes queued commands against the byte store: writes message bytes,
// commits messages with their terminator, pops messages and scans back
// for the previous terminator. Results leave through an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msbs_back import msbs_pkg::*; #(
    parameter int STORE_BYTES = 1024,
    parameter int MAX_MESSAGE = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_cmd              i_q_cmd,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_out_byte_valid,
    output logic [ST_W-1:0]   o_status,
    output logic              o_last_of_result,
    output logic [CNT_W-1:0]  o_byte_count
);

    localparam int AW   = $clog2(STORE_BYTES);
    localparam int UW   = $clog2(STORE_BYTES + 1);
    localparam int SUMW = ((UW > CNT_W) ? UW : CNT_W) + 2;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_COMMIT   = 3'd1;
    localparam logic [2:0] S_EMPTY    = 3'd2;
    localparam logic [2:0] S_NONE     = 3'd3;
    localparam logic [2:0] S_RD_ISSUE = 3'd4;
    localparam logic [2:0] S_RD_WAIT  = 3'd5;
    localparam logic [2:0] S_SCAN     = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [UW-1:0]    r_used, n_used;
    logic [AW-1:0]    r_top, n_top;
    logic             r_wip, n_wip;
    logic [ST_W-1:0]  r_rej, n_rej;
    logic [CNT_W-1:0] r_wbc, n_wbc;
    logic             r_stop, n_stop;
    logic [AW-1:0]    r_rd_addr, n_rd_addr;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [AW-1:0]    r_scan_addr, n_scan_addr;
    logic [AW-1:0]    r_chk_addr, n_chk_addr;
    logic             r_pend, n_pend;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_byte_valid;
    logic [ST_W-1:0]   r_out_status;
    logic              r_out_last;
    logic [CNT_W-1:0]  r_out_count;

    logic              out_free;
    logic              out_load;
    logic [BYTE_W-1:0] ld_byte;
    logic              ld_byte_valid;
    logic [ST_W-1:0]   ld_status;
    logic [CNT_W-1:0]  ld_count;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    logic [UW-1:0]    rd_len_full;
    logic [CNT_W-1:0] rd_len;
    logic [CNT_W-1:0] rd_n0;
    logic [CNT_W-1:0] rd_n;
    logic             rd_last;

    logic             w_wip;
    logic             w_stop;
    logic [ST_W-1:0]  w_rej;
    logic [CNT_W-1:0] w_wbc;
    logic             w_room;

    msbs_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Length of the newest message: everything from its start up to the
    // byte before its terminator.
    assign rd_len_full = r_used - UW'(1) - UW'(r_top);
    assign rd_len      = CNT_W'(rd_len_full);
    assign rd_n0       = (rd_len < i_q_cmd.limit) ? rd_len : i_q_cmd.limit;
    assign rd_n        = (rd_n0 > CNT_W'(MAX_MESSAGE)) ? CNT_W'(MAX_MESSAGE) : rd_n0;
    assign rd_last     = (CNT_W'(r_idx + CNT_W'(1)) == r_n);

    assign out_free = !r_out_valid || !i_out_stall;

    // Effective write state once a first item has restarted the message.
    always_comb begin
        w_wip  = r_wip;
        w_stop = r_stop;
        w_rej  = r_rej;
        w_wbc  = r_wbc;
        if (i_q_cmd.first) begin
            w_wip  = 1'b1;
            w_stop = 1'b0;
            w_wbc  = '0;
            if (i_q_cmd.too_long) begin
                w_rej = ST_TOO_LONG;
            end else if (SUMW'(r_used) + SUMW'(i_q_cmd.cap) + SUMW'(1)
                         > SUMW'(STORE_BYTES)) begin
                w_rej = ST_FULL;
            end else begin
                w_rej = ST_OK;
            end
        end
        w_room = (SUMW'(r_used) + SUMW'(w_wbc) + SUMW'(1)) < SUMW'(STORE_BYTES);
    end

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_top       = r_top;
        n_wip       = r_wip;
        n_rej       = r_rej;
        n_wbc       = r_wbc;
        n_stop      = r_stop;
        n_rd_addr   = r_rd_addr;
        n_n         = r_n;
        n_idx       = r_idx;
        n_scan_addr = r_scan_addr;
        n_chk_addr  = r_chk_addr;
        n_pend      = r_pend;
        o_q_pop     = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = AW'(SUMW'(r_used) + SUMW'(w_wbc));
        ram_wdata   = i_q_cmd.data;
        ram_re      = 1'b0;
        ram_raddr   = r_rd_addr;
        out_load    = 1'b0;
        ld_byte       = '0;
        ld_byte_valid = 1'b0;
        ld_status     = ST_OK;
        ld_count      = '0;

        unique case (r_state) inside
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_cmd.op == OP_READ) begin
                        n_wip     = 1'b0;
                        n_rd_addr = r_top;
                        n_n       = rd_n;
                        n_idx     = '0;
                        if (r_used == '0) begin
                            n_state = S_EMPTY;
                        end else if (rd_n == '0) begin
                            n_state = S_NONE;
                        end else begin
                            n_state = S_RD_ISSUE;
                        end
                    end else begin
                        n_wip  = w_wip;
                        n_stop = w_stop;
                        n_rej  = w_rej;
                        n_wbc  = w_wbc;
                        if (w_wip) begin
                            if (w_rej == ST_OK && !w_stop && i_q_cmd.cap != '0) begin
                                if (i_q_cmd.data == '0) begin
                                    n_stop = 1'b1;
                                end else if (w_wbc < i_q_cmd.cap && w_room) begin
                                    ram_we = 1'b1;
                                    n_wbc  = w_wbc + CNT_W'(1);
                                end
                            end
                            if (i_q_cmd.last) begin
                                n_wip   = 1'b0;
                                n_state = S_COMMIT;
                            end
                        end
                    end
                end
            end
            S_COMMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_rej != ST_OK) begin
                        ld_status = r_rej;
                    end else begin
                        // The terminator follows the last stored byte.
                        ram_we    = 1'b1;
                        ram_waddr = AW'(SUMW'(r_used) + SUMW'(r_wbc));
                        ram_wdata = '0;
                        n_top     = AW'(r_used);
                        n_used    = UW'(SUMW'(r_used) + SUMW'(r_wbc) + SUMW'(1));
                        ld_count  = r_wbc;
                    end
                    n_rej   = ST_OK;
                    n_wbc   = '0;
                    n_stop  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    ld_status = ST_EMPTY;
                    n_state   = S_IDLE;
                end
            end
            S_NONE, S_RD_WAIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_state == S_RD_WAIT) begin
                        ld_byte       = ram_rdata;
                        ld_byte_valid = 1'b1;
                        ld_count      = rd_last ? r_n : '0;
                        n_idx         = r_idx + CNT_W'(1);
                        n_rd_addr     = r_rd_addr + AW'(1);
                    end
                    if (r_state == S_NONE || rd_last) begin
                        // Pop: the store shrinks to the start of this message,
                        // and the previous start is found by scanning back.
                        n_used = UW'(r_top);
                        if (r_top <= AW'(1)) begin
                            n_top   = '0;
                            n_state = S_IDLE;
                        end else begin
                            n_scan_addr = r_top - AW'(2);
                            n_pend      = 1'b0;
                            n_state     = S_SCAN;
                        end
                    end else begin
                        n_state = S_RD_ISSUE;
                    end
                end
            end
            S_RD_ISSUE: begin
                ram_re  = 1'b1;
                n_state = S_RD_WAIT;
            end
            S_SCAN: begin
                ram_raddr = r_scan_addr;
                if (r_pend && ram_rdata == '0) begin
                    n_top   = r_chk_addr + AW'(1);
                    n_state = S_IDLE;
                end else if (r_pend && r_chk_addr == '0) begin
                    n_top   = '0;
                    n_state = S_IDLE;
                end else begin
                    ram_re      = 1'b1;
                    n_chk_addr  = r_scan_addr;
                    n_scan_addr = r_scan_addr - AW'(1);
                    n_pend      = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_top       <= '0;
            r_wip       <= 1'b0;
            r_rej       <= ST_OK;
            r_wbc       <= '0;
            r_stop      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_top   <= n_top;
            r_wip   <= n_wip;
            r_rej   <= n_rej;
            r_wbc   <= n_wbc;
            r_stop  <= n_stop;
            r_pend  <= n_pend;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr   <= n_rd_addr;
        r_n         <= n_n;
        r_idx       <= n_idx;
        r_scan_addr <= n_scan_addr;
        r_chk_addr  <= n_chk_addr;
        if (out_load) begin
            r_out_byte       <= ld_byte;
            r_out_byte_valid <= ld_byte_valid;
            r_out_status     <= ld_status;
            r_out_last       <= (r_state != S_RD_WAIT) || rd_last;
            r_out_count      <= ld_count;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_out_byte_valid = r_out_byte_valid;
    assign o_status         = r_out_status;
    assign o_last_of_result = r_out_last;
    assign o_byte_count     = r_out_count;

    `MSBS_ASSERT(a_used_range, i_clk, i_rst_n, (r_used <= UW'(STORE_BYTES)),
        "used bytes beyond store size")
    `MSBS_ASSERT(a_top_below_used, i_clk, i_rst_n,
        ((r_state == S_IDLE && r_used != '0) |-> (UW'(r_top) < r_used)),
        "top message start not below used bytes")
    `MSBS_ASSERT(a_write_states, i_clk, i_rst_n,
        (ram_we |-> (r_state == S_IDLE || r_state == S_COMMIT)),
        "store written during a pop")
    `MSBS_ASSERT(a_mid_result_has_byte, i_clk, i_rst_n,
        ((o_out_valid && !o_last_of_result) |-> o_out_byte_valid),
        "non-final result carries no byte")
    `MSBS_ASSERT_NEXT(a_commit_result, i_clk, i_rst_n, (r_state == S_COMMIT && out_free),
        (o_out_valid && o_last_of_result && !o_out_byte_valid),
        "commit did not produce a final write result")

endmodule

### hw/rtl/message_stack_byte_store.sv
// The executor takes write items from the queue while idle; the closing item
// of a message adds a commit step to store the terminator and return its result.
// A pop returns its bytes one at a time (store read, then output register),
// then scans back one store byte per cycle for the previous terminator.
// Synchronous active-low reset clears control state; the byte store is not cleared.
// ----------------------------------------------------------------------------
// message_stack_byte_store
// Last-in-first-out stack of variable-length byte messages packed into one
// byte store with a zero terminator after each message.
// ----------------------------------------------------------------------------
module message_stack_byte_store import msbs_pkg::*; #(
    parameter int STORE_BYTES = 1024,
    parameter int MAX_MESSAGE = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_kind,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic [MLEN_W-1:0] i_message_length,
    input  logic              i_first_of_message,
    input  logic              i_last_of_message,
    input  logic [CNT_W-1:0]  i_read_limit,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_out_byte_valid,
    output logic [ST_W-1:0]   o_status,
    output logic              o_last_of_result,
    output logic [CNT_W-1:0]  o_byte_count
);

    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    msbs_front #(
        .MAX_MESSAGE (MAX_MESSAGE)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_kind             (i_kind),
        .i_data_byte        (i_data_byte),
        .i_message_length   (i_message_length),
        .i_first_of_message (i_first_of_message),
        .i_last_of_message  (i_last_of_message),
        .i_read_limit       (i_read_limit),
        .o_q_valid          (q_valid),
        .o_q_cmd            (q_cmd),
        .i_q_pop            (q_pop)
    );

    msbs_back #(
        .STORE_BYTES (STORE_BYTES),
        .MAX_MESSAGE (MAX_MESSAGE)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_cmd          (q_cmd),
        .o_q_pop          (q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_byte       (o_out_byte),
        .o_out_byte_valid (o_out_byte_valid),
        .o_status         (o_status),
        .o_last_of_result (o_last_of_result),
        .o_byte_count     (o_byte_count)
    );

endmodule

### tb/tb_message_stack_byte_store.sv
// ----------------------------------------------------------------------------
// tb_message_stack_byte_store
// Self-checking bench for the byte-store message stack. A scoreboard class
// keeps its own copy of the stack and predicts every result transaction;
// directed pushes and pops and random traffic run under random idling, a stretch
// of pushes and pops runs without idling; one long back-pressure hold is applied.
// ----------------------------------------------------------------------------
module tb_message_stack_byte_store;
    timeunit 1ns;
    timeprecision 1ps;
    import msbs_pkg::*;

    localparam int STORE_BYTES     = 1024;
    localparam int MAX_MESSAGE     = 64;
    localparam int RANDOM_ITEMS    = 95;
    localparam int STEADY_MESSAGES = 3;
    localparam int STEADY_LENGTH   = 8;
    localparam int HOLD_CYCLES     = 400;
    localparam int HOLD_AFTER      = 40;
    localparam int SETTLE_CYCLES   = 100;
    localparam int WATCHDOG_CYCLES = 4000;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data_byte;
        logic [MLEN_W-1:0] message_length;
        logic              first_of_message;
        logic              last_of_message;
        logic [CNT_W-1:0]  read_limit;
    } t_stack_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_byte_valid;
        logic [ST_W-1:0]   status;
        logic              last_of_result;
        logic [CNT_W-1:0]  byte_count;
    } t_stack_result;

    class stack_scoreboard;
        logic [BYTE_W-1:0] store_mem [STORE_BYTES];
        int unsigned       used_bytes;
        int unsigned       top_start;
        int unsigned       write_count;
        bit                in_message;
        bit                stopped;
        logic [ST_W-1:0]   rejection;
        t_stack_result     awaited_results [$];
        int                errors;
        int                results_seen;
        int                status_seen [4];

        function new();
            foreach (store_mem[a]) store_mem[a] = '0;
            foreach (status_seen[s]) status_seen[s] = 0;
            used_bytes   = 0;
            top_start    = 0;
            write_count  = 0;
            in_message   = 0;
            stopped      = 0;
            rejection    = ST_OK;
            errors       = 0;
            results_seen = 0;
        endfunction

        function void await_result(logic [BYTE_W-1:0] b, logic v, logic [ST_W-1:0] st,
                                   logic l, int unsigned cnt);
            t_stack_result r;
            r.out_byte       = b;
            r.out_byte_valid = v;
            r.status         = st;
            r.last_of_result = l;
            r.byte_count     = cnt[CNT_W-1:0];
            awaited_results.push_back(r);
        endfunction

        function void pop_message(logic [CNT_W-1:0] limit);
            int unsigned len;
            int unsigned n;
            int unsigned p;
            in_message = 0;
            if (used_bytes == 0) begin
                await_result('0, 1'b0, ST_EMPTY, 1'b1, 0);
                return;
            end
            len = used_bytes - 1 - top_start;
            n = (len < limit) ? len : limit;
            if (n > MAX_MESSAGE) n = MAX_MESSAGE;
            for (int unsigned i = 0; i < n; i++)
                await_result(store_mem[(top_start + i) % STORE_BYTES], 1'b1, ST_OK,
                             i + 1 == n, (i + 1 == n) ? n : 0);
            if (n == 0) await_result('0, 1'b0, ST_OK, 1'b1, 0);
            // The new top starts right after the terminator below the popped message.
            used_bytes = top_start;
            if (used_bytes == 0) begin
                top_start = 0;
            end else begin
                p = used_bytes - 1;
                while (p > 0 && store_mem[(p - 1) % STORE_BYTES] != 0) p--;
                top_start = p;
            end
        endfunction

        // Runs one accepted input transaction through the stack.
        function void take_item(t_stack_item it);
            if (it.kind == OP_READ) begin
                pop_message(it.read_limit);
                return;
            end
            if (it.first_of_message) begin
                in_message  = 1;
                write_count = 0;
                stopped     = 0;
                if (it.message_length > MAX_MESSAGE)
                    rejection = ST_TOO_LONG;
                else if (used_bytes + it.message_length + 1 > STORE_BYTES)
                    rejection = ST_FULL;
                else
                    rejection = ST_OK;
            end
            if (!in_message) return;
            if (rejection == ST_OK && !stopped && it.message_length > 0) begin
                if (it.data_byte == 0) begin
                    stopped = 1;
                end else if (write_count < it.message_length && write_count < MAX_MESSAGE &&
                             used_bytes + write_count + 1 < STORE_BYTES) begin
                    store_mem[used_bytes + write_count] = it.data_byte;
                    write_count++;
                end
            end
            if (!it.last_of_message) return;
            in_message = 0;
            if (rejection != ST_OK) begin
                await_result('0, 1'b0, rejection, 1'b1, 0);
                rejection   = ST_OK;
                write_count = 0;
                return;
            end
            top_start = used_bytes;
            store_mem[used_bytes + write_count] = '0;
            used_bytes = used_bytes + write_count + 1;
            await_result('0, 1'b0, ST_OK, 1'b1, write_count);
            write_count = 0;
            stopped     = 0;
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH %s", $time, msg);
            errors++;
        endtask

        task check_result(t_stack_result got);
            t_stack_result want;
            results_seen++;
            if (awaited_results.size() == 0) begin
                report($sformatf({"result with nothing awaited: ",
                                  "byte=%h v=%b st=%0d last=%b cnt=%0d"},
                                 got.out_byte, got.out_byte_valid, got.status,
                                 got.last_of_result, got.byte_count));
                return;
            end
            want = awaited_results.pop_front();
            status_seen[want.status]++;
            if (got.out_byte !== want.out_byte || got.out_byte_valid !== want.out_byte_valid ||
                got.status !== want.status || got.last_of_result !== want.last_of_result ||
                got.byte_count !== want.byte_count)
                report($sformatf({"result %0d: got byte=%h v=%b st=%0d last=%b cnt=%0d, ",
                                  "want byte=%h v=%b st=%0d last=%b cnt=%0d"}, results_seen,
                                 got.out_byte, got.out_byte_valid, got.status,
                                 got.last_of_result, got.byte_count,
                                 want.out_byte, want.out_byte_valid, want.status,
                                 want.last_of_result, want.byte_count));
        endtask

        task report_leftovers();
            if (awaited_results.size() != 0)
                report($sformatf("%0d awaited results never arrived", awaited_results.size()));
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_kind;
    logic [BYTE_W-1:0] i_data_byte;
    logic [MLEN_W-1:0] i_message_length;
    logic              i_first_of_message;
    logic              i_last_of_message;
    logic [CNT_W-1:0]  i_read_limit;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_out_byte_valid;
    logic [ST_W-1:0]   o_status;
    logic              o_last_of_result;
    logic [CNT_W-1:0]  o_byte_count;

    stack_scoreboard sb;
    bit steady = 1'b0;
    int items_sent = 0;
    int ignored_items = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int quiet_cycles = 0;

    message_stack_byte_store #(
        .STORE_BYTES(STORE_BYTES),
        .MAX_MESSAGE(MAX_MESSAGE)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_kind            (i_kind),
        .i_data_byte       (i_data_byte),
        .i_message_length  (i_message_length),
        .i_first_of_message(i_first_of_message),
        .i_last_of_message (i_last_of_message),
        .i_read_limit      (i_read_limit),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_byte        (o_out_byte),
        .o_out_byte_valid  (o_out_byte_valid),
        .o_status          (o_status),
        .o_last_of_result  (o_last_of_result),
        .o_byte_count      (o_byte_count)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [BYTE_W-1:0] rand_byte(int zero_pct);
        if ($urandom_range(0, 99) < zero_pct) return '0;
        return BYTE_W'($urandom_range(1, 255));
    endfunction

    function automatic int rand_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 16);
        if (r < 90) return $urandom_range(17, MAX_MESSAGE);
        return $urandom_range(MAX_MESSAGE + 1, 255);
    endfunction

    function automatic int rand_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return 0;
        if (r < 40) return MAX_MESSAGE;
        return $urandom_range(1, MAX_MESSAGE - 1);
    endfunction

    // Number of write items that carry a message of the given length.
    function automatic int item_span(int mlen);
        if (mlen == 0) return 1;
        if (mlen > MAX_MESSAGE) return $urandom_range(1, 4);
        return mlen;
    endfunction

    function automatic t_stack_item write_item(logic [BYTE_W-1:0] data, int mlen,
                                               bit first, bit last);
        t_stack_item it;
        it.kind             = OP_WRITE;
        it.data_byte        = data;
        it.message_length   = mlen[MLEN_W-1:0];
        it.first_of_message = first;
        it.last_of_message  = last;
        it.read_limit       = CNT_W'($urandom_range(0, MAX_MESSAGE));
        return it;
    endfunction

    function automatic t_stack_item read_item(int limit);
        t_stack_item it;
        it.kind             = OP_READ;
        it.data_byte        = BYTE_W'($urandom_range(0, 255));
        it.message_length   = MLEN_W'($urandom_range(0, 255));
        it.first_of_message = 1'($urandom_range(0, 1));
        it.last_of_message  = 1'($urandom_range(0, 1));
        it.read_limit       = limit[CNT_W-1:0];
        return it;
    endfunction

    task automatic send_item(input t_stack_item it);
        if (!steady) begin
            while ($urandom_range(0, 99) < 33) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid         <= 1'b1;
        i_kind             <= it.kind;
        i_data_byte        <= it.data_byte;
        i_message_length   <= it.message_length;
        i_first_of_message <= it.first_of_message;
        i_last_of_message  <= it.last_of_message;
        i_read_limit       <= it.read_limit;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_item(it);
        items_sent++;
    endtask

    task automatic send_message(int mlen, int nitems, int zero_pct, bit closed);
        for (int k = 0; k < nitems; k++)
            send_item(write_item(rand_byte(zero_pct), mlen, k == 0, closed && k == nitems - 1));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.awaited_results.size() != 0);
    endtask

    // Result side: checks accepted results and applies back-pressure.
    always @(posedge i_clk) begin
        t_stack_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.out_byte       = o_out_byte;
            got.out_byte_valid = o_out_byte_valid;
            got.status         = o_status;
            got.last_of_result = o_last_of_result;
            got.byte_count     = o_byte_count;
            sb.check_result(got);
        end
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && sb.results_seen >= HOLD_AFTER) begin
            // One long hold-off so that the block backs up and stalls its input.
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !steady && ($urandom_range(0, 99) < 33);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_CYCLES) begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG_CYCLES);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int sel;
        int mlen;
        int random_goal;
        sb = new();
        i_rst_n            <= 1'b0;
        i_in_valid         <= 1'b0;
        i_kind             <= OP_WRITE;
        i_data_byte        <= '0;
        i_message_length   <= '0;
        i_first_of_message <= 1'b0;
        i_last_of_message  <= 1'b0;
        i_read_limit       <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty stack, empty message, rejections and ragged messages.
        send_item(read_item(MAX_MESSAGE));
        send_item(write_item(8'hFF, 0, 1'b1, 1'b1));
        send_item(read_item(MAX_MESSAGE));
        send_item(write_item(8'h01, 3, 1'b1, 1'b0));
        send_item(write_item(8'hFF, 3, 1'b0, 1'b0));
        send_item(write_item(8'h80, 3, 1'b0, 1'b1));
        send_item(write_item(8'hAA, 255, 1'b1, 1'b1));
        send_item(write_item(8'h12, MAX_MESSAGE + 1, 1'b1, 1'b0));
        send_item(write_item(8'h13, MAX_MESSAGE + 1, 1'b0, 1'b1));
        // A zero data byte ends the stored part of the message.
        send_item(write_item(8'h11, 4, 1'b1, 1'b0));
        send_item(write_item(8'h00, 4, 1'b0, 1'b0));
        send_item(write_item(8'h22, 4, 1'b0, 1'b1));
        send_item(write_item(8'h7F, 2, 1'b1, 1'b0));
        send_item(write_item(8'h40, 2, 1'b0, 1'b0));
        send_item(write_item(8'h55, 2, 1'b0, 1'b1));
        send_item(write_item(8'h33, 5, 1'b1, 1'b0));
        send_item(write_item(8'h44, 5, 1'b0, 1'b1));
        send_item(write_item(8'h99, 3, 1'b0, 1'b1));
        // Restart a message before it closes, then abandon one with a pop.
        send_item(write_item(8'h21, 2, 1'b1, 1'b0));
        send_item(write_item(8'h31, 2, 1'b1, 1'b0));
        send_item(write_item(8'h32, 2, 1'b0, 1'b1));
        send_item(write_item(8'h5A, 8, 1'b1, 1'b0));
        send_item(read_item(1));
        send_item(read_item(0));
        send_item(read_item(MAX_MESSAGE - 1));
        wait_drained();

        // No idling on either side: a few pushes, then pops down to an empty stack.
        steady = 1'b1;
        for (int m = 0; m < STEADY_MESSAGES; m++)
            send_message(STEADY_LENGTH, STEADY_LENGTH, 0, 1'b1);
        while (sb.used_bytes != 0)
            send_item(read_item(MAX_MESSAGE));
        steady = 1'b0;
        send_item(read_item(rand_limit()));
        wait_drained();

        // Random traffic: mostly well-formed messages and pops, some noise.
        random_goal = items_sent + RANDOM_ITEMS;
        while (items_sent - ignored_items < random_goal) begin
            sel  = $urandom_range(0, 99);
            mlen = rand_length();
            if (sel < 55) begin
                send_message(mlen, item_span(mlen), 5, 1'b1);
            end else if (sel < 80) begin
                send_item(read_item(rand_limit()));
            end else if (sel < 88) begin
                mlen = $urandom_range(0, 16);
                send_message(mlen, (mlen < 3) ? $urandom_range(1, 4) :
                             mlen + $urandom_range(0, 6) - 3, 5, 1'b1);
            end else if (sel < 93) begin
                // A write item with no message open is dropped by the block.
                send_item(write_item(rand_byte(5), mlen, 1'b0, 1'($urandom_range(0, 1))));
                ignored_items++;
            end else if (sel < 97) begin
                send_message(mlen, $urandom_range(1, 3), 5, 1'b0);
                mlen = rand_length();
                send_message(mlen, item_span(mlen), 5, 1'b1);
            end else begin
                send_message(mlen, $urandom_range(1, 3), 5, 1'b0);
                send_item(read_item(rand_limit()));
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.report_leftovers();
        $display("Run covered %0d input transactions (%0d stray write items) and %0d results,",
                 items_sent, ignored_items, sb.results_seen);
        $display("with statuses ok %0d, too long %0d, full %0d, empty %0d.",
                 sb.status_seen[ST_OK], sb.status_seen[ST_TOO_LONG],
                 sb.status_seen[ST_FULL], sb.status_seen[ST_EMPTY]);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
